FILE: rtl/svgbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgbf_pkg
// Shared types, codes and helpers of the path segment flattener.
// ----------------------------------------------------------------------------
package svgbf_pkg;

    localparam int COORD_W         = 32;
    localparam int STEP_W          = 7;
    localparam int SQ_W            = 13;
    localparam int WGT_W           = 19;
    localparam int ACC_W           = 52;
    localparam int MAG_W           = 51;
    localparam int SHIFT_W         = 5;
    localparam int CNT_W           = 2;
    localparam int MAX_STEPS       = 64;
    localparam int DEF_CURVE_STEPS = 48;

    typedef logic [3:0] t_action;
    localparam t_action ACT_MOVE   = 4'd0;
    localparam t_action ACT_LINE   = 4'd1;
    localparam t_action ACT_HORIZ  = 4'd2;
    localparam t_action ACT_VERT   = 4'd3;
    localparam t_action ACT_CUBIC  = 4'd4;
    localparam t_action ACT_SCUBIC = 4'd5;
    localparam t_action ACT_QUAD   = 4'd6;
    localparam t_action ACT_SQUAD  = 4'd7;
    localparam t_action ACT_CLOSE  = 4'd8;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_CUBIC,
        KIND_QUAD
    } t_kind;

    typedef enum logic [2:0] {
        OSEL_END,
        OSEL_CUR,
        OSEL_START,
        OSEL_LINE,
        OSEL_CURVE
    } t_osel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DRAW,
        ST_WGT1,
        ST_WGT2,
        ST_MAC,
        ST_DIVI,
        ST_DIV,
        ST_PT
    } t_state;

    typedef struct packed {
        logic  load;
        logic  out_load;
        t_osel out_sel;
        logic  out_begin;
        logic  out_closed;
        logic  out_last;
        logic  do_move;
        logic  do_close;
        logic  do_open;
        logic  do_line;
        logic  curve_setup;
        logic  wgt1;
        logic  wgt2;
        logic  mac;
        logic  div_start;
        logic  div_step;
        logic  curve_next;
        logic  curve_done;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    is_open;
        logic    out_free;
        logic    mac_done;
        logic    div_done;
        logic    step_last;
    } t_status;

    function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        logic [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1]) begin
            return s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        return s[COORD_W-1:0];
    endfunction

    // 2*p - c, saturated
    function automatic logic [COORD_W-1:0] reflect(input logic [COORD_W-1:0] p,
                                                   input logic [COORD_W-1:0] c);
        logic [COORD_W+1:0] t;
        t = {p[COORD_W-1], p, 1'b0} - {{2{c[COORD_W-1]}}, c};
        if (t[COORD_W+1:COORD_W-1] == 3'b000 || t[COORD_W+1:COORD_W-1] == 3'b111) begin
            return t[COORD_W-1:0];
        end
        return t[COORD_W+1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    // signed result from magnitude quotient, saturated
    function automatic logic [COORD_W-1:0] sat_quot(input logic [MAG_W-1:0] q,
                                                    input logic neg);
        logic [COORD_W-1:0] lo;
        lo = q[COORD_W-1:0];
        if (!neg) begin
            if (q > MAG_W'({1'b0, {(COORD_W-1){1'b1}}})) return {1'b0, {(COORD_W-1){1'b1}}};
            return lo;
        end
        if (q > MAG_W'({1'b1, {(COORD_W-1){1'b0}}})) return {1'b1, {(COORD_W-1){1'b0}}};
        return ~lo + COORD_W'(1);
    endfunction

endpackage

FILE: rtl/svgbf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgbf_datapath
// Path state, curve weight/accumulate/divide unit and output register.
// ----------------------------------------------------------------------------
module svgbf_datapath #(
    parameter int CURVE_STEPS = svgbf_pkg::DEF_CURVE_STEPS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  svgbf_pkg::t_cmd     i_cmd,
    output svgbf_pkg::t_status  o_status,
    input  logic [191:0]        i_s_axis_tdata,
    input  logic [4:0]          i_s_axis_tuser,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [63:0]         o_m_axis_tdata,
    output logic [1:0]          o_m_axis_tuser,
    output logic                o_m_axis_tlast
);

    localparam int CW = svgbf_pkg::COORD_W;
    localparam int SW = svgbf_pkg::STEP_W;
    localparam int QW = svgbf_pkg::SQ_W;
    localparam int WW = svgbf_pkg::WGT_W;
    localparam int AW = svgbf_pkg::ACC_W;
    localparam int MW = svgbf_pkg::MAG_W;
    localparam int HW = svgbf_pkg::SHIFT_W;
    localparam int NW = svgbf_pkg::CNT_W;
    localparam int STEPS_C = (CURVE_STEPS < 1) ? 1 :
                             ((CURVE_STEPS > svgbf_pkg::MAX_STEPS) ? svgbf_pkg::MAX_STEPS
                                                                   : CURVE_STEPS);
    localparam logic [SW-1:0] STEPS = SW'(STEPS_C);
    localparam logic [SW-1:0] STEPS_MAX = SW'(svgbf_pkg::MAX_STEPS);

    // divisors for the full and the shortened step count, with reciprocals
    localparam int STEPS_B = (STEPS_C > 1) ? STEPS_C - 1 : 1;
    localparam int D3A = STEPS_C * STEPS_C * STEPS_C;
    localparam int D2A = STEPS_C * STEPS_C;
    localparam int D3B = STEPS_B * STEPS_B * STEPS_B;
    localparam int D2B = STEPS_B * STEPS_B;
    localparam int S3A = $clog2(D3A);
    localparam int S2A = $clog2(D2A);
    localparam int S3B = $clog2(D3B);
    localparam int S2B = $clog2(D2B);
    localparam logic [CW-1:0] R3A = CW'((64'd1 << (S3A + CW)) / 64'(D3A) - (64'd1 << CW));
    localparam logic [CW-1:0] R2A = CW'((64'd1 << (S2A + CW)) / 64'(D2A) - (64'd1 << CW));
    localparam logic [CW-1:0] R3B = CW'((64'd1 << (S3B + CW)) / 64'(D3B) - (64'd1 << CW));
    localparam logic [CW-1:0] R2B = CW'((64'd1 << (S2B + CW)) / 64'(D2B) - (64'd1 << CW));
    localparam logic [HW-1:0] H3A = HW'(S3A);
    localparam logic [HW-1:0] H2A = HW'(S2A);
    localparam logic [HW-1:0] H3B = HW'(S3B);
    localparam logic [HW-1:0] H2B = HW'(S2B);

    svgbf_pkg::t_action r_act;
    logic [CW-1:0] r_c1x, r_c1y, r_c2x, r_c2y, r_ex, r_ey;
    logic [CW-1:0] r_cx, r_cy, r_sx, r_sy, r_kx, r_ky;
    svgbf_pkg::t_kind r_kind;
    logic          r_open, r_opened;
    logic [SW-1:0] r_n, r_step;
    logic [QW-1:0] r_mm, r_mi, r_ii, r_nn;
    logic [WW-1:0] r_w [4];
    logic [WW-1:0] r_den;
    logic [CW-1:0] r_rlo;
    logic [HW-1:0] r_sh;
    logic [1:0]    r_term;
    logic signed [AW-1:0] r_accx, r_accy;
    logic [MW-1:0] r_numx, r_numy;
    logic [2*CW-1:0] r_prx, r_pry;
    logic [CW-1:0] r_qx, r_qy;
    logic [MW-1:0] r_remx, r_remy;
    logic          r_negx, r_negy;
    logic [NW-1:0] r_dcnt;
    logic          r_ovalid, r_obeg, r_ocls, r_olast;
    logic [CW-1:0] r_opx, r_opy;

    logic [CW-1:0] ox, oy, line_x, line_y, sel_x, sel_y, px, py;
    logic [CW-1:0] qx, qy;
    logic [SW-1:0] m;
    logic          cubic, smooth, full_n;
    logic [WW-1:0] w_cur;
    logic signed [AW-1:0] prod_x, prod_y, abs_x, abs_y;
    logic [MW-1:0] mag_x, mag_y;
    logic [CW-1:0] ntop_x, ntop_y;
    logic [MW-1:0] den_m, qd_x, qd_y;
    logic [2*QW-1:0] t_mmm, t_mmi, t_mii, t_iii, t_nnn;

    assign cubic  = (r_act == svgbf_pkg::ACT_CUBIC) || (r_act == svgbf_pkg::ACT_SCUBIC);
    assign smooth = (r_act == svgbf_pkg::ACT_SCUBIC) || (r_act == svgbf_pkg::ACT_SQUAD);
    assign full_n = (r_n == STEPS);
    assign m      = r_n - r_step;

    assign ox = i_s_axis_tuser[4] ? r_cx : '0;
    assign oy = i_s_axis_tuser[4] ? r_cy : '0;

    assign line_x = (r_act == svgbf_pkg::ACT_VERT)  ? r_cx : r_ex;
    assign line_y = (r_act == svgbf_pkg::ACT_HORIZ) ? r_cy : r_ey;

    assign t_mmm = {{QW{1'b0}}, r_mm} * {{(2*QW-SW){1'b0}}, m};
    assign t_mmi = {{QW{1'b0}}, r_mm} * {{(2*QW-SW){1'b0}}, r_step};
    assign t_mii = {{QW{1'b0}}, r_ii} * {{(2*QW-SW){1'b0}}, m};
    assign t_iii = {{QW{1'b0}}, r_ii} * {{(2*QW-SW){1'b0}}, r_step};
    assign t_nnn = {{QW{1'b0}}, r_nn} * {{(2*QW-SW){1'b0}}, r_n};

    // control point for each Bernstein term
    always_comb begin
        unique case (r_term)
            2'd0: begin px = r_cx;  py = r_cy;  end
            2'd1: begin px = r_c1x; py = r_c1y; end
            2'd2: begin px = cubic ? r_c2x : r_ex; py = cubic ? r_c2y : r_ey; end
            default: begin px = r_ex; py = r_ey; end
        endcase
        w_cur = r_w[r_term];
    end

    assign prod_x = $signed({1'b0, w_cur}) * $signed(px);
    assign prod_y = $signed({1'b0, w_cur}) * $signed(py);

    assign abs_x = r_accx[AW-1] ? -r_accx : r_accx;
    assign abs_y = r_accy[AW-1] ? -r_accy : r_accy;
    assign mag_x = abs_x[MW-1:0] + MW'(r_den >> 1);
    assign mag_y = abs_y[MW-1:0] + MW'(r_den >> 1);

    // numerator scaled down so the reciprocal product stays 32 by 32 bits
    assign ntop_x = CW'(r_numx >> r_sh);
    assign ntop_y = CW'(r_numy >> r_sh);
    assign den_m  = {{(MW-WW){1'b0}}, r_den};
    assign qd_x   = {{(MW-CW){1'b0}}, r_qx} * den_m;
    assign qd_y   = {{(MW-CW){1'b0}}, r_qy} * den_m;

    assign qx = svgbf_pkg::sat_quot({{(MW-CW){1'b0}}, r_qx}, r_negx);
    assign qy = svgbf_pkg::sat_quot({{(MW-CW){1'b0}}, r_qy}, r_negy);

    always_comb begin
        unique case (i_cmd.out_sel)
            svgbf_pkg::OSEL_END:   begin sel_x = r_ex;   sel_y = r_ey;   end
            svgbf_pkg::OSEL_CUR:   begin sel_x = r_cx;   sel_y = r_cy;   end
            svgbf_pkg::OSEL_START: begin sel_x = r_sx;   sel_y = r_sy;   end
            svgbf_pkg::OSEL_LINE:  begin sel_x = line_x; sel_y = line_y; end
            default:               begin sel_x = qx;     sel_y = qy;     end
        endcase
    end

    // path state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0; r_cy <= '0; r_sx <= '0; r_sy <= '0; r_kx <= '0; r_ky <= '0;
            r_kind <= svgbf_pkg::KIND_NONE;
            r_open <= 1'b0;
            r_opened <= 1'b0;
        end else begin
            if (i_cmd.load) r_opened <= 1'b0;
            if (i_cmd.do_move) begin
                r_cx <= r_ex; r_cy <= r_ey; r_sx <= r_ex; r_sy <= r_ey;
                r_kx <= r_ex; r_ky <= r_ey;
                r_open <= 1'b1;
                r_kind <= svgbf_pkg::KIND_NONE;
            end
            if (i_cmd.do_close) begin
                r_cx <= r_sx; r_cy <= r_sy; r_kx <= r_sx; r_ky <= r_sy;
                r_open <= 1'b0;
                r_kind <= svgbf_pkg::KIND_NONE;
            end
            if (i_cmd.do_open) begin
                r_sx <= r_cx; r_sy <= r_cy;
                r_open <= 1'b1;
                r_opened <= 1'b1;
            end
            if (i_cmd.do_line) begin
                r_cx <= line_x; r_cy <= line_y; r_kx <= line_x; r_ky <= line_y;
                r_kind <= svgbf_pkg::KIND_NONE;
            end
            if (i_cmd.curve_done) begin
                r_cx <= r_ex; r_cy <= r_ey;
                r_kx <= cubic ? r_c2x : r_c1x;
                r_ky <= cubic ? r_c2y : r_c1y;
                r_kind <= cubic ? svgbf_pkg::KIND_CUBIC : svgbf_pkg::KIND_QUAD;
            end
        end
    end

    // segment operands and curve arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_s_axis_tuser[3:0];
            r_c1x <= svgbf_pkg::sat_add(i_s_axis_tdata[31:0], ox);
            r_c1y <= svgbf_pkg::sat_add(i_s_axis_tdata[63:32], oy);
            r_c2x <= svgbf_pkg::sat_add(i_s_axis_tdata[95:64], ox);
            r_c2y <= svgbf_pkg::sat_add(i_s_axis_tdata[127:96], oy);
            r_ex  <= svgbf_pkg::sat_add(i_s_axis_tdata[159:128], ox);
            r_ey  <= svgbf_pkg::sat_add(i_s_axis_tdata[191:160], oy);
        end
        if (i_cmd.curve_setup) begin
            if (smooth) begin
                if ((cubic && r_kind == svgbf_pkg::KIND_CUBIC) ||
                    (!cubic && r_kind == svgbf_pkg::KIND_QUAD)) begin
                    r_c1x <= svgbf_pkg::reflect(r_cx, r_kx);
                    r_c1y <= svgbf_pkg::reflect(r_cy, r_ky);
                end else begin
                    r_c1x <= r_cx;
                    r_c1y <= r_cy;
                end
            end
            // a curve that also opened the subpath stays within 64 points
            r_n <= (r_opened && STEPS == STEPS_MAX) ? STEPS - SW'(1) : STEPS;
            r_step <= SW'(1);
        end
        if (i_cmd.curve_next) r_step <= r_step + SW'(1);
        if (i_cmd.wgt1) begin
            r_mm <= QW'({{(QW-SW){1'b0}}, m} * {{(QW-SW){1'b0}}, m});
            r_mi <= QW'({{(QW-SW){1'b0}}, m} * {{(QW-SW){1'b0}}, r_step});
            r_ii <= QW'({{(QW-SW){1'b0}}, r_step} * {{(QW-SW){1'b0}}, r_step});
            r_nn <= QW'({{(QW-SW){1'b0}}, r_n} * {{(QW-SW){1'b0}}, r_n});
        end
        if (i_cmd.wgt2) begin
            if (cubic) begin
                r_w[0] <= WW'(t_mmm);
                r_w[1] <= WW'((t_mmi << 1) + t_mmi);
                r_w[2] <= WW'((t_mii << 1) + t_mii);
                r_w[3] <= WW'(t_iii);
                r_den  <= WW'(t_nnn);
                r_rlo  <= full_n ? R3A : R3B;
                r_sh   <= full_n ? H3A : H3B;
            end else begin
                r_w[0] <= WW'(r_mm);
                r_w[1] <= WW'({r_mi, 1'b0});
                r_w[2] <= WW'(r_ii);
                r_w[3] <= '0;
                r_den  <= WW'(r_nn);
                r_rlo  <= full_n ? R2A : R2B;
                r_sh   <= full_n ? H2A : H2B;
            end
            r_accx <= '0;
            r_accy <= '0;
            r_term <= 2'd0;
        end
        if (i_cmd.mac) begin
            r_accx <= r_accx + prod_x;
            r_accy <= r_accy + prod_y;
            r_term <= r_term + 2'd1;
        end
        if (i_cmd.div_start) begin
            r_numx <= mag_x; r_numy <= mag_y;
            r_negx <= r_accx[AW-1]; r_negy <= r_accy[AW-1];
            r_dcnt <= '0;
        end
        // reciprocal estimate, low by at most three, then unit corrections
        if (i_cmd.div_step) begin
            unique case (r_dcnt)
                NW'(0): begin
                    r_prx <= {{CW{1'b0}}, ntop_x} * {{CW{1'b0}}, r_rlo};
                    r_pry <= {{CW{1'b0}}, ntop_y} * {{CW{1'b0}}, r_rlo};
                end
                NW'(1): begin
                    r_qx <= ntop_x + r_prx[2*CW-1:CW];
                    r_qy <= ntop_y + r_pry[2*CW-1:CW];
                end
                NW'(2): begin
                    r_remx <= r_numx - qd_x;
                    r_remy <= r_numy - qd_y;
                end
                default: begin
                    if (r_remx >= den_m) begin
                        r_remx <= r_remx - den_m;
                        r_qx   <= r_qx + CW'(1);
                    end
                    if (r_remy >= den_m) begin
                        r_remy <= r_remy - den_m;
                        r_qy   <= r_qy + CW'(1);
                    end
                end
            endcase
            if (r_dcnt != NW'(3)) r_dcnt <= r_dcnt + NW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_opx   <= sel_x;
            r_opy   <= sel_y;
            r_obeg  <= i_cmd.out_begin;
            r_ocls  <= i_cmd.out_closed;
            r_olast <= i_cmd.out_last;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_opy, r_opx};
    assign o_m_axis_tuser  = {r_ocls, r_obeg};
    assign o_m_axis_tlast  = r_olast;

    assign o_status.action    = r_act;
    assign o_status.is_open   = r_open;
    assign o_status.out_free  = !r_ovalid || i_m_axis_tready;
    assign o_status.mac_done  = (r_term == (cubic ? 2'd3 : 2'd2));
    assign o_status.div_done  = (r_dcnt == NW'(3)) && (r_remx < den_m) && (r_remy < den_m);
    assign o_status.step_last = (r_step == r_n);

endmodule

FILE: rtl/svgbf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgbf_ctrl
// Segment sequencer: decodes the action and steps the curve unit.
// ----------------------------------------------------------------------------
module svgbf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  svgbf_pkg::t_status  i_status,
    output svgbf_pkg::t_cmd     o_cmd
);

    svgbf_pkg::t_state r_state, n_state;
    logic draw_act, is_curve_line;

    assign draw_act = (i_status.action != svgbf_pkg::ACT_MOVE) &&
                      (i_status.action != svgbf_pkg::ACT_CLOSE);
    assign is_curve_line = (i_status.action == svgbf_pkg::ACT_LINE) ||
                           (i_status.action == svgbf_pkg::ACT_HORIZ) ||
                           (i_status.action == svgbf_pkg::ACT_VERT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= svgbf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            svgbf_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) n_state = svgbf_pkg::ST_DECODE;
            end
            svgbf_pkg::ST_DECODE: begin
                if (i_status.action > svgbf_pkg::ACT_CLOSE) begin
                    n_state = svgbf_pkg::ST_IDLE;
                end else if (i_status.action == svgbf_pkg::ACT_MOVE) begin
                    if (i_status.out_free) n_state = svgbf_pkg::ST_IDLE;
                end else if (i_status.action == svgbf_pkg::ACT_CLOSE) begin
                    if (!i_status.is_open || i_status.out_free) n_state = svgbf_pkg::ST_IDLE;
                end else if (i_status.is_open || i_status.out_free) begin
                    n_state = svgbf_pkg::ST_DRAW;
                end
            end
            svgbf_pkg::ST_DRAW: begin
                if (!is_curve_line) n_state = svgbf_pkg::ST_WGT1;
                else if (i_status.out_free) n_state = svgbf_pkg::ST_IDLE;
            end
            svgbf_pkg::ST_WGT1: n_state = svgbf_pkg::ST_WGT2;
            svgbf_pkg::ST_WGT2: n_state = svgbf_pkg::ST_MAC;
            svgbf_pkg::ST_MAC: begin
                if (i_status.mac_done) n_state = svgbf_pkg::ST_DIVI;
            end
            svgbf_pkg::ST_DIVI: n_state = svgbf_pkg::ST_DIV;
            svgbf_pkg::ST_DIV: begin
                if (i_status.div_done) n_state = svgbf_pkg::ST_PT;
            end
            svgbf_pkg::ST_PT: begin
                if (i_status.out_free) begin
                    n_state = i_status.step_last ? svgbf_pkg::ST_IDLE : svgbf_pkg::ST_WGT1;
                end
            end
            default: n_state = svgbf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.out_sel = svgbf_pkg::OSEL_END;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            svgbf_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                o_cmd.load = i_s_axis_tvalid;
            end
            svgbf_pkg::ST_DECODE: begin
                if (i_status.action == svgbf_pkg::ACT_MOVE) begin
                    if (i_status.out_free) begin
                        o_cmd.out_load  = 1'b1;
                        o_cmd.out_sel   = svgbf_pkg::OSEL_END;
                        o_cmd.out_begin = 1'b1;
                        o_cmd.out_last  = 1'b1;
                        o_cmd.do_move   = 1'b1;
                    end
                end else if (i_status.action == svgbf_pkg::ACT_CLOSE) begin
                    if (!i_status.is_open) begin
                        o_cmd.do_close = 1'b1;
                    end else if (i_status.out_free) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_sel    = svgbf_pkg::OSEL_START;
                        o_cmd.out_closed = 1'b1;
                        o_cmd.out_last   = 1'b1;
                        o_cmd.do_close   = 1'b1;
                    end
                end else if (draw_act && i_status.action <= svgbf_pkg::ACT_CLOSE &&
                             !i_status.is_open && i_status.out_free) begin
                    // drawing with no subpath opens one at the current point
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_sel   = svgbf_pkg::OSEL_CUR;
                    o_cmd.out_begin = 1'b1;
                    o_cmd.do_open   = 1'b1;
                end
            end
            svgbf_pkg::ST_DRAW: begin
                if (!is_curve_line) begin
                    o_cmd.curve_setup = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = svgbf_pkg::OSEL_LINE;
                    o_cmd.out_last = 1'b1;
                    o_cmd.do_line  = 1'b1;
                end
            end
            svgbf_pkg::ST_WGT1: o_cmd.wgt1 = 1'b1;
            svgbf_pkg::ST_WGT2: o_cmd.wgt2 = 1'b1;
            svgbf_pkg::ST_MAC:  o_cmd.mac = 1'b1;
            svgbf_pkg::ST_DIVI: o_cmd.div_start = 1'b1;
            svgbf_pkg::ST_DIV:  o_cmd.div_step = 1'b1;
            svgbf_pkg::ST_PT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_sel    = svgbf_pkg::OSEL_CURVE;
                    o_cmd.out_last   = i_status.step_last;
                    o_cmd.curve_done = i_status.step_last;
                    o_cmd.curve_next = !i_status.step_last;
                end
            end
            default: ;
        endcase
    end

    a_load_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == svgbf_pkg::ST_DECODE))
        else $error("accepted item not decoded");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("output register overwritten");

    a_div_after_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == svgbf_pkg::ST_DIVI) |-> $past(r_state == svgbf_pkg::ST_MAC))
        else $error("divider started without accumulate");

endmodule

FILE: rtl/svg_path_bezier_flattener_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svg_path_bezier_flattener_unit
// Flattens tokenised path segments into a polyline of Q16.16 points.
// ----------------------------------------------------------------------------
// Input channel: one path segment per item; tuser holds the action code and
// the relative flag, tdata the control and end coordinates.
// Output channel: one polyline point per item; tuser flags subpath begin and
// close, tlast marks the final point of a segment.
// Moves, closes and lines are decoded and written out directly. A curve is
// set up and then gives CURVE_STEPS points (held to 1..64, one fewer at 64
// when the curve opened the subpath); each point passes the weight states,
// a multiply-accumulate per Bernstein term, divide setup, reciprocal divide
// with correction and the output state, so the divider sets the curve rate.
// One segment is in work at a time; the next is taken once the previous one
// has handed its last point to the output register.
// Reset clears the current point, subpath start, control point and the
// subpath flag to zero and empties the output register.
// A stalled receiver holds the output register; the sequencer waits with
// the next point until the register is free.
// ----------------------------------------------------------------------------
module svg_path_bezier_flattener_unit #(
    parameter int CURVE_STEPS = svgbf_pkg::DEF_CURVE_STEPS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
    input  logic [191:0] i_s_axis_tdata,
    // action[3:0], relative[4]
    input  logic [4:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // point_x, point_y
    output logic [63:0]  o_m_axis_tdata,
    // subpath_begin[0], subpath_closed[1]
    output logic [1:0]   o_m_axis_tuser,
    output logic         o_m_axis_tlast
);

    svgbf_pkg::t_cmd    cmd;
    svgbf_pkg::t_status status;

    svgbf_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    svgbf_datapath #(
        .CURVE_STEPS (CURVE_STEPS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
